/* rtl/bmcb_pkg.sv */
// shared types, register indexes and helpers for the bounded message counter bank
package bmcb_pkg;

    localparam int LABEL_W    = 8;
    localparam int VALUE_W    = 8;
    localparam int COUNT_W    = 9;
    localparam int BITS_W     = 4;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef logic [OP_W-1:0]      t_op;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_op OP_INC = 2'd1;
    localparam t_op OP_DEC = 2'd2;

    localparam t_cfg_idx REG_MSG_BOUND     = 3'd0;
    localparam t_cfg_idx REG_COUNTER_BITS  = 3'd1;
    localparam t_cfg_idx REG_NUM_LABELS    = 3'd2;
    localparam t_cfg_idx REG_RECEIVE_FIRST = 3'd3;
    localparam t_cfg_idx REG_RECEIVE_LAST  = 3'd4;

    // counter width clamped to 1..8
    function automatic logic [VALUE_W-1:0] width_mask(input logic [BITS_W-1:0] bits);
        logic [BITS_W-1:0] b;
        logic [VALUE_W:0]  full;
        b = bits;
        if (b == 4'd0) begin
            b = 4'd1;
        end else if (b > 4'd8) begin
            b = 4'd8;
        end
        full = (9'd1 << b) - 9'd1;
        return full[VALUE_W-1:0];
    endfunction

endpackage

/* rtl/bmcb_ram.sv */
// generic single write port ram with registered read
module bmcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bounded_message_counter_bank.sv */
// top level of the bounded message counter bank
// One transaction is accepted every clock cycle; busy is never raised. A transaction
// accepted at one rising edge has its result on the result ports, marked by
// o_result_strobe, after the registered counter ram read and then one update stage
// that writes the counter back and loads the result registers. Back-to-back
// transactions on the same label are forwarded, so throughput stays at one per cycle.
// Results must be taken as they come. A configuration write to a listed register
// clears every counter and running count; the configuration port is always ready.
module bounded_message_counter_bank
    import bmcb_pkg::*;
#(
    parameter int MAX_LABELS = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [OP_W-1:0]       i_op,
    input  logic [LABEL_W-1:0]    i_label,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_result_strobe,
    output logic [VALUE_W-1:0]    o_count_value,
    output logic                  o_op_ok,
    output logic                  o_label_marked,
    output logic                  o_all_unmarked,
    output logic                  o_pending_output,
    output logic                  o_within_bound,
    output logic                  o_label_error
);

    localparam int DEPTH = (MAX_LABELS < 256) ? MAX_LABELS : 256;
    localparam int AW    = $clog2(DEPTH);

    // configuration
    logic [VALUE_W-1:0] r_msg_bound;
    logic [BITS_W-1:0]  r_counter_bits;
    logic [LABEL_W-1:0] r_num_labels;
    logic [LABEL_W-1:0] r_receive_first;
    logic [LABEL_W-1:0] r_receive_last;

    logic cfg_write;
    logic cfg_clear;

    // running counts and entry valid bits
    logic [COUNT_W-1:0] r_nonzero;
    logic [COUNT_W-1:0] r_nonzero_rx;
    logic [COUNT_W-1:0] r_over_bound;
    logic [COUNT_W-1:0] n_nonzero;
    logic [COUNT_W-1:0] n_nonzero_rx;
    logic [COUNT_W-1:0] n_over_bound;
    logic [DEPTH-1:0]   r_valid;

    // update stage
    logic               r_s1_valid;
    t_op                r_s1_op;
    logic [LABEL_W-1:0] r_s1_label;
    logic               r_s1_err;
    logic               r_s1_fwd;
    logic [VALUE_W-1:0] r_s1_fwd_data;
    logic               r_s1_entry_vld;

    // result registers
    logic               r_out_strobe;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_ok;
    logic               r_out_marked;
    logic               r_out_all_unmarked;
    logic               r_out_pending;
    logic               r_out_within;
    logic               r_out_err;

    logic               accept;
    logic               in_err;
    logic               s1_write;
    logic [VALUE_W-1:0] ram_rdata;
    logic [VALUE_W-1:0] mask;
    logic [VALUE_W-1:0] old_val;
    logic [VALUE_W-1:0] n_value;
    logic               n_ok;
    logic               old_nz;
    logic               nxt_nz;
    logic               in_rx;
    logic               old_over;
    logic               nxt_over;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_comb begin
        case (i_cfg_index)
            REG_MSG_BOUND, REG_COUNTER_BITS, REG_NUM_LABELS,
            REG_RECEIVE_FIRST, REG_RECEIVE_LAST: cfg_clear = cfg_write;
            default: cfg_clear = 1'b0;
        endcase
    end

    assign in_err = (i_label == '0) || (i_label > r_num_labels)
                 || ({1'b0, i_label} >= 9'(DEPTH));

    assign s1_write = r_s1_valid && !r_s1_err;

    bmcb_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_counter_ram (
        .i_clk   (i_clk),
        .i_we    (s1_write),
        .i_waddr (r_s1_label[AW-1:0]),
        .i_wdata (n_value),
        .i_raddr (i_label[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        mask = width_mask(r_counter_bits);
        if (r_s1_fwd) begin
            old_val = r_s1_fwd_data & mask;
        end else if (r_s1_entry_vld) begin
            old_val = ram_rdata & mask;
        end else begin
            old_val = '0;
        end

        n_value = old_val;
        n_ok    = 1'b1;
        case (r_s1_op)
            OP_INC: begin
                n_ok    = old_val < r_msg_bound;
                n_value = (old_val + 8'd1) & mask;
            end
            OP_DEC: begin
                n_ok    = old_val != '0;
                n_value = (old_val + mask) & mask;
            end
            default: begin
                n_ok    = 1'b1;
                n_value = old_val;
            end
        endcase

        old_nz   = old_val != '0;
        nxt_nz   = n_value != '0;
        in_rx    = (r_s1_label >= r_receive_first) && (r_s1_label <= r_receive_last);
        old_over = old_val > r_msg_bound;
        nxt_over = n_value > r_msg_bound;

        n_nonzero    = r_nonzero;
        n_nonzero_rx = r_nonzero_rx;
        n_over_bound = r_over_bound;
        if (s1_write && (old_nz != nxt_nz)) begin
            if (nxt_nz) begin
                n_nonzero = r_nonzero + 9'd1;
                if (in_rx) begin
                    n_nonzero_rx = r_nonzero_rx + 9'd1;
                end
            end else begin
                n_nonzero = r_nonzero - 9'd1;
                if (in_rx) begin
                    n_nonzero_rx = r_nonzero_rx - 9'd1;
                end
            end
        end
        if (s1_write && (old_over != nxt_over)) begin
            if (nxt_over) begin
                n_over_bound = r_over_bound + 9'd1;
            end else begin
                n_over_bound = r_over_bound - 9'd1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_bound     <= 8'd1;
            r_counter_bits  <= 4'd1;
            r_num_labels    <= 8'd1;
            r_receive_first <= 8'd1;
            r_receive_last  <= 8'd0;
            r_nonzero       <= '0;
            r_nonzero_rx    <= '0;
            r_over_bound    <= '0;
            r_valid         <= '0;
            r_s1_valid      <= 1'b0;
            r_out_strobe    <= 1'b0;
        end else begin
            r_s1_valid   <= accept;
            r_out_strobe <= r_s1_valid;
            if (cfg_clear) begin
                case (i_cfg_index)
                    REG_MSG_BOUND:     r_msg_bound     <= i_cfg_data;
                    REG_COUNTER_BITS:  r_counter_bits  <= i_cfg_data[BITS_W-1:0];
                    REG_NUM_LABELS:    r_num_labels    <= i_cfg_data;
                    REG_RECEIVE_FIRST: r_receive_first <= i_cfg_data;
                    REG_RECEIVE_LAST:  r_receive_last  <= i_cfg_data;
                    default:           r_msg_bound     <= r_msg_bound;
                endcase
                r_nonzero    <= '0;
                r_nonzero_rx <= '0;
                r_over_bound <= '0;
                r_valid      <= '0;
            end else begin
                r_nonzero    <= n_nonzero;
                r_nonzero_rx <= n_nonzero_rx;
                r_over_bound <= n_over_bound;
                if (s1_write) begin
                    r_valid[r_s1_label[AW-1:0]] <= 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_s1_op        <= i_op;
        r_s1_label     <= i_label;
        r_s1_err       <= in_err;
        r_s1_fwd       <= s1_write && (r_s1_label == i_label);
        r_s1_fwd_data  <= n_value;
        r_s1_entry_vld <= r_valid[i_label[AW-1:0]];

        r_out_value        <= r_s1_err ? '0 : n_value;
        r_out_ok           <= !r_s1_err && n_ok;
        r_out_marked       <= !r_s1_err && nxt_nz;
        r_out_all_unmarked <= n_nonzero == '0;
        r_out_pending      <= n_nonzero_rx != '0;
        r_out_within       <= n_over_bound == '0;
        r_out_err          <= r_s1_err;
    end

    assign o_result_strobe  = r_out_strobe;
    assign o_count_value    = r_out_value;
    assign o_op_ok          = r_out_ok;
    assign o_label_marked   = r_out_marked;
    assign o_all_unmarked   = r_out_all_unmarked;
    assign o_pending_output = r_out_pending;
    assign o_within_bound   = r_out_within;
    assign o_label_error    = r_out_err;

endmodule

/* tb/sv/bounded_message_counter_bank_test.sv */
// testbench for the bounded message counter bank: directed and random counter traffic
module bounded_message_counter_bank_test
    import bmcb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam t_op OP_READ  = 2'd0;
    localparam t_op OP_SPARE = 2'd3;

    typedef struct packed {
        logic [VALUE_W-1:0] count_value;
        logic               op_ok;
        logic               label_marked;
        logic               all_unmarked;
        logic               pending_output;
        logic               within_bound;
        logic               label_error;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [OP_W-1:0]       i_op = '0;
    logic [LABEL_W-1:0]    i_label = '0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_result_strobe;
    logic [VALUE_W-1:0]    o_count_value;
    logic                  o_op_ok;
    logic                  o_label_marked;
    logic                  o_all_unmarked;
    logic                  o_pending_output;
    logic                  o_within_bound;
    logic                  o_label_error;

    // shadow of the configuration and the counter bank
    logic [7:0]         cfg_bound = 8'd1;
    logic [BITS_W-1:0]  cfg_bits = 4'd1;
    logic [7:0]         cfg_labels = 8'd1;
    logic [7:0]         cfg_rx_first = 8'd1;
    logic [7:0]         cfg_rx_last = 8'd0;
    logic [VALUE_W-1:0] bank [0:255];
    logic [COUNT_W-1:0] nonzero_total;
    logic [COUNT_W-1:0] rx_nonzero;
    logic [COUNT_W-1:0] over_bound_total;

    t_result expected_results [$];
    t_result oldest;
    int      errors = 0;

    bounded_message_counter_bank u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_label          (i_label),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_result_strobe  (o_result_strobe),
        .o_count_value    (o_count_value),
        .o_op_ok          (o_op_ok),
        .o_label_marked   (o_label_marked),
        .o_all_unmarked   (o_all_unmarked),
        .o_pending_output (o_pending_output),
        .o_within_bound   (o_within_bound),
        .o_label_error    (o_label_error)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic void clear_bank();
        for (int i = 0; i < 256; i++) begin
            bank[i] = '0;
        end
        nonzero_total    = '0;
        rx_nonzero       = '0;
        over_bound_total = '0;
    endfunction

    function automatic t_result predict_counter_op(input t_op op, input logic [7:0] lab);
        t_result            r;
        logic [BITS_W-1:0]  b;
        logic [VALUE_W:0]   full;
        logic [VALUE_W-1:0] mask;
        logic [VALUE_W-1:0] old;
        logic [VALUE_W-1:0] nxt;
        logic               in_rx;
        r = '0;
        if (lab == 8'd0 || lab > cfg_labels) begin
            r.label_error = 1'b1;
        end else begin
            b = cfg_bits;
            if (b == 4'd0) begin
                b = 4'd1;
            end else if (b > 4'd8) begin
                b = 4'd8;
            end
            full = (9'd1 << b) - 9'd1;
            mask = full[VALUE_W-1:0];
            old  = bank[lab] & mask;
            case (op)
                OP_INC: begin
                    r.op_ok = old < cfg_bound;
                    nxt = (old + 8'd1) & mask;
                end
                OP_DEC: begin
                    r.op_ok = old != 8'd0;
                    nxt = (old + mask) & mask;
                end
                default: begin
                    r.op_ok = 1'b1;
                    nxt = old;
                end
            endcase
            in_rx = lab >= cfg_rx_first && lab <= cfg_rx_last;
            if ((old != 8'd0) != (nxt != 8'd0)) begin
                if (nxt != 8'd0) begin
                    nonzero_total = nonzero_total + 9'd1;
                    if (in_rx) begin
                        rx_nonzero = rx_nonzero + 9'd1;
                    end
                end else begin
                    nonzero_total = nonzero_total - 9'd1;
                    if (in_rx) begin
                        rx_nonzero = rx_nonzero - 9'd1;
                    end
                end
            end
            if ((old > cfg_bound) != (nxt > cfg_bound)) begin
                if (nxt > cfg_bound) begin
                    over_bound_total = over_bound_total + 9'd1;
                end else begin
                    over_bound_total = over_bound_total - 9'd1;
                end
            end
            bank[lab]      = nxt;
            r.count_value  = nxt;
            r.label_marked = nxt != 8'd0;
        end
        r.all_unmarked   = nonzero_total == 9'd0;
        r.pending_output = rx_nonzero != 9'd0;
        r.within_bound   = over_bound_total == 9'd0;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] expected,
                                 input logic [31:0] actual);
        if (expected !== actual) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, expected,
                     actual);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with none expected, count_value %0d", $time,
                         o_count_value);
                errors++;
            end else begin
                oldest = expected_results.pop_front();
                compare_field("count_value", 32'(oldest.count_value), 32'(o_count_value));
                compare_field("op_ok", 32'(oldest.op_ok), 32'(o_op_ok));
                compare_field("label_marked", 32'(oldest.label_marked),
                              32'(o_label_marked));
                compare_field("all_unmarked", 32'(oldest.all_unmarked),
                              32'(o_all_unmarked));
                compare_field("pending_output", 32'(oldest.pending_output),
                              32'(o_pending_output));
                compare_field("within_bound", 32'(oldest.within_bound),
                              32'(o_within_bound));
                compare_field("label_error", 32'(oldest.label_error), 32'(o_label_error));
            end
        end
    end

    task automatic send_item(input t_op op, input logic [7:0] lab, input bit may_idle);
        int gap;
        i_op    <= op;
        i_label <= lab;
        start   <= 1'b1;
        do @(posedge i_clk); while (busy);
        expected_results.insert(expected_results.size(), predict_counter_op(op, lab));
        @(negedge i_clk);
        gap = 0;
        if (may_idle) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: gap = 0;
                6, 7, 8:          gap = $urandom_range(1, 3);
                default:          gap = $urandom_range(5, 40);
            endcase
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_results_done();
        start <= 1'b0;
        do @(negedge i_clk); while (expected_results.size() != 0);
    endtask

    // leaves the write channel valid so writes can follow back to back
    task automatic write_register(input t_cfg_idx idx, input logic [7:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_MSG_BOUND:     cfg_bound    = data;
            REG_COUNTER_BITS:  cfg_bits     = data[BITS_W-1:0];
            REG_NUM_LABELS:    cfg_labels   = data;
            REG_RECEIVE_FIRST: cfg_rx_first = data;
            REG_RECEIVE_LAST:  cfg_rx_last  = data;
            default: ;
        endcase
        clear_bank();
        @(negedge i_clk);
    endtask

    task automatic set_register(input t_cfg_idx idx, input logic [7:0] data);
        wait_results_done();
        write_register(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [7:0] bound, input logic [3:0] bits,
                             input logic [7:0] labels, input logic [7:0] first,
                             input logic [7:0] last);
        wait_results_done();
        write_register(REG_MSG_BOUND, bound);
        write_register(REG_COUNTER_BITS, {4'd0, bits});
        write_register(REG_NUM_LABELS, labels);
        write_register(REG_RECEIVE_FIRST, first);
        write_register(REG_RECEIVE_LAST, last);
        i_cfg_valid <= 1'b0;
    endtask

    // one-bit counters with the settings left from reset
    task automatic test_reset_defaults();
        send_item(OP_READ, 8'd1, 1'b1);
        send_item(OP_INC, 8'd1, 1'b1);
        send_item(OP_INC, 8'd1, 1'b1);
        send_item(OP_DEC, 8'd1, 1'b1);
        send_item(OP_DEC, 8'd1, 1'b1);
        send_item(OP_INC, 8'd0, 1'b1);
        send_item(OP_INC, 8'd2, 1'b1);
        send_item(OP_DEC, 8'd255, 1'b1);
        send_item(OP_SPARE, 8'd1, 1'b1);
    endtask

    // full width counters, wrap in both directions and crossing the bound
    task automatic test_wrap_and_bound();
        configure(8'd3, 4'd8, 8'd255, 8'd255, 8'd255);
        send_item(OP_DEC, 8'd255, 1'b1);
        send_item(OP_INC, 8'd255, 1'b1);
        repeat (4) send_item(OP_INC, 8'd1, 1'b0);
        send_item(OP_READ, 8'd1, 1'b1);
        send_item(OP_SPARE, 8'd254, 1'b1);
        send_item(OP_DEC, 8'd1, 1'b1);
    endtask

    // zero bound, out of range widths, empty receive range, no labels
    task automatic test_odd_config();
        configure(8'd0, 4'd0, 8'd2, 8'd2, 8'd1);
        send_item(OP_INC, 8'd1, 1'b1);
        send_item(OP_INC, 8'd2, 1'b1);
        send_item(OP_DEC, 8'd1, 1'b1);
        set_register(REG_COUNTER_BITS, 8'd15);
        send_item(OP_DEC, 8'd2, 1'b1);
        set_register(REG_NUM_LABELS, 8'd0);
        send_item(OP_READ, 8'd1, 1'b1);
    endtask

    function automatic t_op random_op();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8: return OP_INC;
            9, 10, 11, 12, 13, 14:     return OP_DEC;
            15, 16, 17:                return OP_READ;
            default:                   return OP_SPARE;
        endcase
    endfunction

    function automatic logic [7:0] random_label();
        if (cfg_labels == 8'd0 || $urandom_range(0, 19) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'($urandom_range(1, cfg_labels));
    endfunction

    task automatic test_random_traffic();
        logic [7:0] bound;
        logic [3:0] bits;
        logic [7:0] labels;
        logic [7:0] first;
        logic [7:0] last;
        bit         may_idle;
        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 0) begin
                bound = 8'd255; bits = 4'd8; labels = 8'd255; first = 8'd1; last = 8'd255;
            end else if (phase == 1) begin
                bound = 8'd1; bits = 4'd1; labels = 8'd1; first = 8'd1; last = 8'd1;
            end else begin
                case ($urandom_range(0, 7))
                    0:       bound = 8'd0;
                    1:       bound = 8'd1;
                    2:       bound = 8'd255;
                    default: bound = 8'($urandom_range(1, 6));
                endcase
                case ($urandom_range(0, 5))
                    0:       bits = 4'd0;
                    1:       bits = 4'd8;
                    2:       bits = 4'($urandom_range(9, 15));
                    default: bits = 4'($urandom_range(1, 4));
                endcase
                labels = ($urandom_range(0, 4) == 0) ? 8'd255 : 8'($urandom_range(1, 10));
                first  = 8'($urandom_range(1, labels));
                case ($urandom_range(0, 3))
                    0:       last = first - 8'd1;
                    1:       last = 8'd255;
                    default: last = 8'($urandom_range(first, labels));
                endcase
            end
            configure(bound, bits, labels, first, last);
            may_idle = $urandom_range(0, 3) != 0;
            for (int n = 0; n < 210; n++) begin
                if ($urandom_range(0, 59) == 0) begin
                    wait_results_done();
                end
                send_item(random_op(), random_label(), may_idle);
            end
        end
    endtask

    initial begin
        clear_bank();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_wrap_and_bound();
        test_odd_config();
        test_random_traffic();
        wait_results_done();
        repeat (6) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
